@@ design/amsdu_pkg.sv @@
// Shared types and constants for the A-MSDU aggregation decider.
`default_nettype none

package amsdu_pkg;

    // Field widths of the frame descriptors and of the decisions.
    localparam int LENGTH_W = 16;
    localparam int COUNT_W  = 13;
    localparam int TID_W    = 4;
    localparam int ADDR_W   = 48;

    // Running length plus one frame and one header never reaches 2^18.
    localparam int GROWN_W  = 18;

    // Configuration register widths and the write port's data width.
    localparam int MIN_SUB_W = 14;
    localparam int MIN_LEN_W = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SUBFRAMES        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_AGGREGATE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AMSDU_BYTES      = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [MIN_SUB_W-1:0] MIN_SUBFRAMES_RESET = '1;
    localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RESET    = '1;
    localparam logic [LENGTH_W-1:0]  MAX_AMSDU_RESET     = 16'd4065;

    // The subframe count saturates here; a frame arriving then ends the scan.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Defaults of the top-level parameters.
    localparam int SUBFRAME_HEADER_BYTES_DEFAULT = 14;
    localparam int QUEUE_DEPTH_DEFAULT           = 4;

    // One finished scan, as handed from the front end to the decision stage.
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [LENGTH_W-1:0] length;
    } scan_rec_t;

endpackage

`default_nettype wire

@@ design/amsdu_front.sv @@
// Scan front end: tracks the open scan and emits a record when a scan ends.
`default_nettype none

module amsdu_front #(
    parameter int SUBFRAME_HEADER_BYTES = amsdu_pkg::SUBFRAME_HEADER_BYTES_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               take,
    input  wire logic [amsdu_pkg::LENGTH_W-1:0]     msdu_length,
    input  wire logic [amsdu_pkg::TID_W-1:0]        traffic_id,
    input  wire logic [amsdu_pkg::ADDR_W-1:0]       receiver_addr,
    input  wire logic [amsdu_pkg::ADDR_W-1:0]       transmitter_addr,
    input  wire logic                               is_data,
    input  wire logic                               last_in_queue,
    input  wire logic [amsdu_pkg::LENGTH_W-1:0]     max_amsdu_bytes,
    output logic                                    rec_push,
    output amsdu_pkg::scan_rec_t                    rec
);

    logic [amsdu_pkg::COUNT_W-1:0]  count_reg,  count_next;
    logic [amsdu_pkg::LENGTH_W-1:0] length_reg, length_next;
    logic [amsdu_pkg::TID_W-1:0]    tid_reg,    tid_next;
    logic [amsdu_pkg::ADDR_W-1:0]   ra_reg,     ra_next;
    logic [amsdu_pkg::ADDR_W-1:0]   ta_reg,     ta_next;

    logic [amsdu_pkg::GROWN_W-1:0]  grown;
    logic                           head;
    logic                           same_flow;
    logic                           eligible;

    // Classify the incoming frame against the open scan.
    always_comb
    begin
        head      = (count_reg == '0);
        grown     = amsdu_pkg::GROWN_W'(length_reg) + amsdu_pkg::GROWN_W'(msdu_length)
                  + amsdu_pkg::GROWN_W'(SUBFRAME_HEADER_BYTES);
        same_flow = head || ((traffic_id == tid_reg) && (receiver_addr == ra_reg)
                  && (transmitter_addr == ta_reg));
        eligible  = is_data && (grown <= amsdu_pkg::GROWN_W'(max_amsdu_bytes))
                  && (count_reg != amsdu_pkg::COUNT_MAX) && same_flow;
    end

    // Update the scan and hand out a record when the scan ends.
    always_comb
    begin
        count_next  = count_reg;
        length_next = length_reg;
        tid_next    = tid_reg;
        ra_next     = ra_reg;
        ta_next     = ta_reg;
        rec_push    = 1'b0;
        rec.count   = count_reg;
        rec.length  = length_reg;
        if (take)
        begin
            if (!eligible)
            begin
                // The frame stays in the queue; decide on what was gathered.
                rec_push    = 1'b1;
                count_next  = '0;
                length_next = '0;
            end
            else if (last_in_queue)
            begin
                // The frame joins and closes the scan.
                rec_push    = 1'b1;
                rec.count   = count_reg + 1'b1;
                rec.length  = grown[amsdu_pkg::LENGTH_W-1:0];
                count_next  = '0;
                length_next = '0;
            end
            else
            begin
                count_next  = count_reg + 1'b1;
                length_next = grown[amsdu_pkg::LENGTH_W-1:0];
                if (head)
                begin
                    tid_next = traffic_id;
                    ra_next  = receiver_addr;
                    ta_next  = transmitter_addr;
                end
            end
        end
    end

    // Scan control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            length_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            length_reg <= length_next;
        end
    end

    // Reference addresses of the scan; only read once the scan has a frame.
    always_ff @(posedge clk)
    begin
        tid_reg <= tid_next;
        ra_reg  <= ra_next;
        ta_reg  <= ta_next;
    end

    // An empty scan carries no length.
    a_empty_scan_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (length_reg == '0))
        else $error("scan without frames holds a length");

    // Every record handed out is a fresh scan on the next cycle.
    a_push_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |=> (count_reg == '0))
        else $error("scan not cleared after a decision");

endmodule

`default_nettype wire

@@ design/amsdu_queue.sv @@
// Short queue of finished scans between the front end and the decision stage.
`default_nettype none

module amsdu_queue #(
    parameter int QUEUE_DEPTH = amsdu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr,
    input  wire amsdu_pkg::scan_rec_t wr_rec,
    input  wire logic                 rd,
    output amsdu_pkg::scan_rec_t      rd_rec,
    output logic                      not_empty,
    output logic                      is_full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    amsdu_pkg::scan_rec_t mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg,  level_next;

    assign not_empty = (level_reg != '0);
    assign is_full   = (level_reg == LVL_W'(QUEUE_DEPTH));
    assign rd_rec    = mem[rd_ptr_reg];

    // Pointer wrap and fill level.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        level_next = level_reg + LVL_W'(wr) - LVL_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

    // The front end must never write a full queue, nor the back end read an empty one.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && is_full) && !(rd && !not_empty))
        else $error("scan queue overflow or underflow");

endmodule

`default_nettype wire

@@ design/amsdu_back.sv @@
// Decision stage: applies the thresholds and holds the decision for the consumer.
`default_nettype none

module amsdu_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire amsdu_pkg::scan_rec_t               head_rec,
    input  wire logic                               head_valid,
    output logic                                    head_take,
    input  wire logic [amsdu_pkg::MIN_SUB_W-1:0]    min_subframes,
    input  wire logic [amsdu_pkg::MIN_LEN_W-1:0]    min_aggregate_length,
    input  wire logic                               pop,
    output logic                                    empty,
    output logic                                    aggregate,
    output logic [amsdu_pkg::COUNT_W-1:0]           frames_taken,
    output logic [amsdu_pkg::LENGTH_W-1:0]          amsdu_length
);

    logic                            valid_reg, valid_next;
    logic                            agg_reg;
    logic [amsdu_pkg::COUNT_W-1:0]   frames_reg;
    logic [amsdu_pkg::LENGTH_W-1:0]  length_reg;

    logic sub_ok;
    logic len_ok;
    logic agg;

    // Thresholds; an all-ones register switches its check off.
    always_comb
    begin
        sub_ok = (min_subframes == '1)
              || ($signed(min_subframes) <= $signed({1'b0, head_rec.count}));
        len_ok = (min_aggregate_length == '1)
              || ($signed(min_aggregate_length) <= $signed({1'b0, head_rec.length}));
        agg    = (head_rec.count > amsdu_pkg::COUNT_W'(1)) && sub_ok && len_ok;
    end

    // Output register is refilled whenever it is free or being drained.
    assign head_take  = head_valid && (!valid_reg || pop);
    assign valid_next = head_take || (valid_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_take)
        begin
            agg_reg    <= agg;
            frames_reg <= agg ? head_rec.count : amsdu_pkg::COUNT_W'(1);
            length_reg <= agg ? head_rec.length : '0;
        end
    end

    assign empty        = !valid_reg;
    assign aggregate    = agg_reg;
    assign frames_taken = frames_reg;
    assign amsdu_length = length_reg;

    // A single-frame decision carries no length; an aggregate has several frames.
    a_decision_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (agg_reg ? (frames_reg > amsdu_pkg::COUNT_W'(1))
                               : ((frames_reg == amsdu_pkg::COUNT_W'(1))
                                  && (length_reg == '0))))
        else $error("malformed decision");

endmodule

`default_nettype wire

@@ design/amsdu_aggregation_decider_core.sv @@
// Top level of the A-MSDU aggregation decider.
//
// Frame descriptors from the head of a transmit queue are taken one per clock
// (push while full is low); each is classified against the open scan in the
// cycle it arrives, using the running-length sum and the TID and address
// compares. A scan that ends drops a record into a queue of QUEUE_DEPTH
// entries, from which it is loaded into the output register that drives the
// result ports once that register is free or being popped. full is high
// exactly when that queue holds QUEUE_DEPTH records. A frame that ends a scan
// without joining it is not consumed and must be presented again.
// Configuration writes take effect at the next edge.
`default_nettype none

module amsdu_aggregation_decider_core #(
    parameter int SUBFRAME_HEADER_BYTES = amsdu_pkg::SUBFRAME_HEADER_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH           = amsdu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write port.
    input  wire logic                                cfg_write,
    input  wire logic [amsdu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [amsdu_pkg::CFG_W-1:0]         cfg_data,
    // Frame descriptors.
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [amsdu_pkg::LENGTH_W-1:0]      msdu_length,
    input  wire logic [amsdu_pkg::TID_W-1:0]         traffic_id,
    input  wire logic [amsdu_pkg::ADDR_W-1:0]        receiver_addr,
    input  wire logic [amsdu_pkg::ADDR_W-1:0]        transmitter_addr,
    input  wire logic                                is_data,
    input  wire logic                                last_in_queue,
    // Decisions.
    output logic                                     empty,
    input  wire logic                                pop,
    output logic                                     aggregate,
    output logic [amsdu_pkg::COUNT_W-1:0]            frames_taken,
    output logic [amsdu_pkg::LENGTH_W-1:0]           amsdu_length
);

    logic [amsdu_pkg::MIN_SUB_W-1:0] min_subframes_reg;
    logic [amsdu_pkg::MIN_LEN_W-1:0] min_length_reg;
    logic [amsdu_pkg::LENGTH_W-1:0]  max_amsdu_reg;

    logic                 take;
    logic                 rec_push;
    amsdu_pkg::scan_rec_t rec;
    amsdu_pkg::scan_rec_t head_rec;
    logic                 head_valid;
    logic                 head_take;
    logic                 q_full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_subframes_reg <= amsdu_pkg::MIN_SUBFRAMES_RESET;
            min_length_reg    <= amsdu_pkg::MIN_LENGTH_RESET;
            max_amsdu_reg     <= amsdu_pkg::MAX_AMSDU_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                amsdu_pkg::REG_MIN_SUBFRAMES:
                    min_subframes_reg <= cfg_data[amsdu_pkg::MIN_SUB_W-1:0];
                amsdu_pkg::REG_MIN_AGGREGATE_LENGTH:
                    min_length_reg    <= cfg_data[amsdu_pkg::MIN_LEN_W-1:0];
                amsdu_pkg::REG_MAX_AMSDU_BYTES:
                    max_amsdu_reg     <= cfg_data[amsdu_pkg::LENGTH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Input transfer.
    assign full = q_full;
    assign take = push && !q_full;

    amsdu_front #(
        .SUBFRAME_HEADER_BYTES(SUBFRAME_HEADER_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .msdu_length      (msdu_length),
        .traffic_id       (traffic_id),
        .receiver_addr    (receiver_addr),
        .transmitter_addr (transmitter_addr),
        .is_data          (is_data),
        .last_in_queue    (last_in_queue),
        .max_amsdu_bytes  (max_amsdu_reg),
        .rec_push         (rec_push),
        .rec              (rec)
    );

    amsdu_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (rec_push),
        .wr_rec    (rec),
        .rd        (head_take),
        .rd_rec    (head_rec),
        .not_empty (head_valid),
        .is_full   (q_full)
    );

    amsdu_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .head_rec             (head_rec),
        .head_valid           (head_valid),
        .head_take            (head_take),
        .min_subframes        (min_subframes_reg),
        .min_aggregate_length (min_length_reg),
        .pop                  (pop),
        .empty                (empty),
        .aggregate            (aggregate),
        .frames_taken         (frames_taken),
        .amsdu_length         (amsdu_length)
    );

endmodule

`default_nettype wire
